// ===== src/mlsq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsq_pkg
// Command and status codes shared by the list stack/queue engine.
// ----------------------------------------------------------------------------
package mlsq_pkg;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_PUSH   = 2'd1,
    KIND_POP    = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_NO_LIST = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  localparam int unsigned ValueW = 32;

endpackage

// ===== src/mlsq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mlsq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mlsq_alloc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsq_alloc
// Node allocator: free-list head plus bump pointer for never-used nodes.
// ----------------------------------------------------------------------------
module mlsq_alloc #(
  parameter int unsigned NUM_NODES = 256,
  localparam int unsigned NW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1,
  localparam int unsigned FW = $clog2(NUM_NODES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,       // consume node_o
  input  logic [NW-1:0] link_i,       // link of the current free head
  input  logic          give_i,       // return give_node_i to the free list
  input  logic [NW-1:0] give_node_i,
  output logic          avail_o,
  output logic [NW-1:0] node_o,
  output logic [NW-1:0] free_head_o,
  output logic          free_nonempty_o
);

  logic [NW-1:0] free_head_q, free_head_d;
  logic          free_ne_q, free_ne_d;
  logic [FW-1:0] fresh_q, fresh_d;
  logic          fresh_left;

  assign fresh_left      = (fresh_q < FW'(NUM_NODES));
  assign avail_o         = free_ne_q | fresh_left;
  assign node_o          = free_ne_q ? free_head_q : fresh_q[NW-1:0];
  assign free_head_o     = free_head_q;
  assign free_nonempty_o = free_ne_q;

  always_comb begin
    free_head_d = free_head_q;
    free_ne_d   = free_ne_q;
    fresh_d     = fresh_q;
    if (take_i) begin
      if (free_ne_q) begin
        free_head_d = link_i;
        // last free node links to itself
        if (link_i == free_head_q) begin
          free_ne_d = 1'b0;
        end
      end else if (fresh_left) begin
        fresh_d = fresh_q + FW'(1);
      end
    end else if (give_i) begin
      free_head_d = give_node_i;
      free_ne_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      free_ne_q   <= 1'b0;
      fresh_q     <= '0;
    end else begin
      free_head_q <= free_head_d;
      free_ne_q   <= free_ne_d;
      fresh_q     <= fresh_d;
    end
  end

endmodule

// ===== src/multi_list_stack_queue_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_list_stack_queue_engine
// Numbered stacks and queues sharing one linked node store.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred at a rising edge with start high and busy low.
//   busy stays high while the command runs. Exactly one result follows: done_o
//   is high for one cycle with status_o, popped_value_o and popped_valid_o,
//   and the receiver must take it then; it cannot stall the block.
//   done_o rises in the cycle right after the last working cycle, and busy is
//   already low in that cycle, so the next command may be transferred there.
// States per command (transfer to next possible transfer):
//   create, errors, push to a stack or to an empty queue: S_EXEC only
//   pop: S_EXEC, S_POP; push to a non-empty queue: S_EXEC, S_LINK
//   The extra state is a second pass through the node RAM read port: pop must
//   read the head node, a queue push must read-modify-write the tail node.
// Reset: all lists cleared to "not created", free list empty, bump pointer
//   at node 0. No clearing pass; the block is ready right after reset.
// ----------------------------------------------------------------------------
module multi_list_stack_queue_engine
  import mlsq_pkg::*;
#(
  parameter int unsigned NUM_LISTS = 16,
  parameter int unsigned NUM_NODES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind_i,
  input  logic [3:0]         list_id_i,
  input  logic               make_queue_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] popped_value_o,
  output logic               popped_valid_o
);

  localparam int unsigned NW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int unsigned LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int unsigned IW = (LW > 4) ? LW : 4;
  localparam int unsigned NodeW = ValueW + NW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_LINK = 2'd3;

  logic [1:0] state_q, state_d;

  // captured command
  logic [1:0]        kind_q;
  logic [LW-1:0]     idx_q;
  logic              id_ok_q;
  logic              mq_q;
  logic [ValueW-1:0] val_q;
  logic [NW-1:0]     head_q, tail_q, n_q;
  logic [NW-1:0]     head_d, tail_d, n_d;

  logic [IW-1:0] id_ext;
  logic [LW-1:0] idx_in;
  logic          id_ok_in;
  logic          accept;

  assign id_ext   = IW'(list_id_i);
  assign idx_in   = id_ext[LW-1:0];
  assign id_ok_in = (32'(list_id_i) < NUM_LISTS);
  assign accept   = start && (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);

  // per-list flags
  logic exists_q [NUM_LISTS];
  logic queue_q  [NUM_LISTS];
  logic nonemp_q [NUM_LISTS];
  logic set_create, set_nonemp, clr_nonemp;

  // list RAM: {head, tail}
  logic            lr_we;
  logic [2*NW-1:0] lr_wdata, lr_rdata;
  logic [NW-1:0]   l_head, l_tail;

  assign l_head = lr_rdata[2*NW-1:NW];
  assign l_tail = lr_rdata[NW-1:0];

  // node RAM: {value, link}
  logic             nr_we;
  logic [NW-1:0]    nr_waddr, nr_raddr;
  logic [NodeW-1:0] nr_wdata, nr_rdata;
  logic [ValueW-1:0] n_value;
  logic [NW-1:0]    n_link;

  assign n_value = nr_rdata[NodeW-1:NW];
  assign n_link  = nr_rdata[NW-1:0];

  // allocator
  logic          al_take, al_give, al_avail, al_free_ne;
  logic [NW-1:0] al_node, al_free_head;

  // result
  logic              done_q, done_d;
  logic [2:0]        status_q, status_d;
  logic [ValueW-1:0] pval_q, pval_d;
  logic              pvalid_q, pvalid_d;

  mlsq_ram #(
    .WIDTH (2 * NW),
    .DEPTH (NUM_LISTS)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (lr_we),
    .waddr_i (idx_q),
    .wdata_i (lr_wdata),
    .raddr_i (idx_in),
    .rdata_o (lr_rdata)
  );

  mlsq_ram #(
    .WIDTH (NodeW),
    .DEPTH (NUM_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (nr_we),
    .waddr_i (nr_waddr),
    .wdata_i (nr_wdata),
    .raddr_i (nr_raddr),
    .rdata_o (nr_rdata)
  );

  mlsq_alloc #(
    .NUM_NODES (NUM_NODES)
  ) u_alloc (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (al_take),
    .link_i          (n_link),
    .give_i          (al_give),
    .give_node_i     (head_q),
    .avail_o         (al_avail),
    .node_o          (al_node),
    .free_head_o     (al_free_head),
    .free_nonempty_o (al_free_ne)
  );

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    n_d        = n_q;
    lr_we      = 1'b0;
    lr_wdata   = {head_q, tail_q};
    nr_we      = 1'b0;
    nr_waddr   = n_q;
    nr_wdata   = {val_q, n_q};
    // idle: prefetch the free head's link for a possible push
    nr_raddr   = al_free_head;
    al_take    = 1'b0;
    al_give    = 1'b0;
    set_create = 1'b0;
    set_nonemp = 1'b0;
    clr_nonemp = 1'b0;
    done_d     = 1'b0;
    status_d   = status_q;
    pval_d     = '0;
    pvalid_d   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        head_d   = l_head;
        tail_d   = l_tail;
        n_d      = al_node;
        status_d = ST_OK;
        done_d   = 1'b1;
        state_d  = S_IDLE;
        if (kind_q == KIND_UNUSED) begin
          status_d = ST_OK;
        end else if (!id_ok_q) begin
          status_d = ST_NO_LIST;
        end else begin
          unique case (kind_q)
            KIND_CREATE: begin
              if (exists_q[idx_q]) begin
                status_d = ST_EXISTS;
              end else begin
                set_create = 1'b1;
              end
            end
            KIND_PUSH: begin
              if (!exists_q[idx_q]) begin
                status_d = ST_NO_LIST;
              end else if (!al_avail) begin
                status_d = ST_FULL;
              end else begin
                al_take    = 1'b1;
                set_nonemp = 1'b1;
                lr_we      = 1'b1;
                nr_we      = 1'b1;
                nr_waddr   = al_node;
                if (!nonemp_q[idx_q]) begin
                  nr_wdata = {val_q, al_node};
                  lr_wdata = {al_node, al_node};
                end else if (queue_q[idx_q]) begin
                  // old tail must be relinked: read it, patch next cycle
                  nr_wdata = {val_q, al_node};
                  lr_wdata = {l_head, al_node};
                  nr_raddr = l_tail;
                  done_d   = 1'b0;
                  state_d  = S_LINK;
                end else begin
                  nr_wdata = {val_q, l_head};
                  lr_wdata = {al_node, l_tail};
                end
              end
            end
            KIND_POP: begin
              if (!exists_q[idx_q]) begin
                status_d = ST_NO_LIST;
              end else if (!nonemp_q[idx_q]) begin
                status_d = ST_EMPTY;
              end else begin
                nr_raddr = l_head;
                done_d   = 1'b0;
                state_d  = S_POP;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_POP: begin
        pval_d   = n_value;
        pvalid_d = 1'b1;
        if (head_q == tail_q) begin
          clr_nonemp = 1'b1;
        end else begin
          lr_we    = 1'b1;
          lr_wdata = {n_link, tail_q};
        end
        al_give  = 1'b1;
        nr_we    = 1'b1;
        nr_waddr = head_q;
        nr_wdata = {n_value, al_free_ne ? al_free_head : head_q};
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      S_LINK: begin
        nr_we    = 1'b1;
        nr_waddr = tail_q;
        nr_wdata = {n_value, n_q};
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        exists_q[i] <= 1'b0;
        queue_q[i]  <= 1'b0;
        nonemp_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (set_create) begin
        exists_q[idx_q] <= 1'b1;
        queue_q[idx_q]  <= mq_q;
        nonemp_q[idx_q] <= 1'b0;
      end
      if (set_nonemp) begin
        nonemp_q[idx_q] <= 1'b1;
      end
      if (clr_nonemp) begin
        nonemp_q[idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      idx_q   <= idx_in;
      id_ok_q <= id_ok_in;
      mq_q    <= make_queue_i;
      val_q   <= value_i;
    end
    head_q   <= head_d;
    tail_q   <= tail_d;
    n_q      <= n_d;
    status_q <= status_d;
    pval_q   <= pval_d;
    pvalid_q <= pvalid_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign popped_value_o = pval_q;
  assign popped_valid_o = pvalid_q;

endmodule

// ===== bench/multi_list_stack_queue_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_list_stack_queue_engine_tb
// Drives create/push/pop commands into the list engine and checks every
// status and popped value against a cycle-free software copy of the node
// store, free list and bump pointer kept inside the bench.
// ----------------------------------------------------------------------------
module multi_list_stack_queue_engine_tb;
  import mlsq_pkg::*;

  localparam int NumLists = 16;
  localparam int NumNodes = 256;
  localparam int SettleCycles = 6;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] popped_value;
    logic               popped_valid;
  } engine_reply_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         kind_i = KIND_CREATE;
  logic [3:0]         list_id_i = '0;
  logic               make_queue_i = 1'b0;
  logic signed [31:0] value_i = '0;
  logic               done_o;
  logic [2:0]         status_o;
  logic signed [31:0] popped_value_o;
  logic               popped_valid_o;

  multi_list_stack_queue_engine #(
    .NUM_LISTS(NumLists),
    .NUM_NODES(NumNodes)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .list_id_i     (list_id_i),
    .make_queue_i  (make_queue_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .popped_value_o(popped_value_o),
    .popped_valid_o(popped_valid_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the engine state
  logic              lst_exists   [NumLists];
  logic              lst_queue    [NumLists];
  logic              lst_nonempty [NumLists];
  logic [7:0]        lst_head     [NumLists];
  logic [7:0]        lst_tail     [NumLists];
  logic [31:0]       nd_value     [NumNodes];
  logic [7:0]        nd_link      [NumNodes];
  logic [7:0]        free_top;
  logic              free_valid;
  logic [8:0]        fresh_ptr;

  engine_reply_t awaited_results[$];
  int idle_pct;
  int cmds_sent;
  int replies_checked;
  int pops_with_data;
  int full_replies;
  int mismatches;

  // Applies one command to the shadow store and returns the reply it must give.
  function automatic engine_reply_t step_lists(input logic [1:0] kind, input logic [3:0] id,
                                               input logic mq, input logic [31:0] val);
    engine_reply_t r;
    logic [7:0]    n;
    logic [7:0]    h;
    logic          got;
    r.status       = ST_OK;
    r.popped_value = '0;
    r.popped_valid = 1'b0;
    got            = 1'b1;
    n              = '0;
    case (kind)
      KIND_CREATE: begin
        if (lst_exists[id]) begin
          r.status = ST_EXISTS;
        end else begin
          lst_exists[id]   = 1'b1;
          lst_queue[id]    = mq;
          lst_nonempty[id] = 1'b0;
        end
      end
      KIND_PUSH: begin
        if (!lst_exists[id]) begin
          r.status = ST_NO_LIST;
        end else begin
          if (free_valid) begin
            n        = free_top;
            free_top = nd_link[n];
            // free chain ends in a self link
            if (free_top == n) free_valid = 1'b0;
          end else if (fresh_ptr < NumNodes) begin
            n         = fresh_ptr[7:0];
            fresh_ptr = fresh_ptr + 9'd1;
          end else begin
            got = 1'b0;
          end
          if (!got) begin
            r.status = ST_FULL;
          end else begin
            nd_value[n] = val;
            nd_link[n]  = n;
            if (!lst_nonempty[id]) begin
              lst_head[id]     = n;
              lst_tail[id]     = n;
              lst_nonempty[id] = 1'b1;
            end else if (lst_queue[id]) begin
              nd_link[lst_tail[id]] = n;
              lst_tail[id]          = n;
            end else begin
              nd_link[n]   = lst_head[id];
              lst_head[id] = n;
            end
          end
        end
      end
      KIND_POP: begin
        if (!lst_exists[id]) begin
          r.status = ST_NO_LIST;
        end else if (!lst_nonempty[id]) begin
          r.status = ST_EMPTY;
        end else begin
          h              = lst_head[id];
          r.popped_value = nd_value[h];
          r.popped_valid = 1'b1;
          if (h == lst_tail[id]) lst_nonempty[id] = 1'b0;
          else lst_head[id] = nd_link[h];
          nd_link[h] = free_valid ? free_top : h;
          free_top   = h;
          free_valid = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Holds start until the engine takes the command; start stays high on return
  // so back-to-back commands never lower and raise it in one step.
  task automatic send_cmd(input logic [1:0] kind, input logic [3:0] id, input logic mq,
                          input logic [31:0] val);
    int            gap;
    engine_reply_t reply;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    kind_i       <= kind;
    list_id_i    <= id;
    make_queue_i <= mq;
    value_i      <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    reply = step_lists(kind, id, mq, val);
    awaited_results.insert(awaited_results.size(), reply);
    cmds_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(15))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Result checker: the receiver cannot stall, so every strobe is a transfer.
  always @(posedge clk_i) begin
    engine_reply_t exp;
    if (rst_ni && done_o === 1'b1) begin
      if (awaited_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing outstanding: status=%0d value=%0d valid=%0b",
                                status_o, popped_value_o, popped_valid_o));
      end else begin
        exp = awaited_results.pop_front();
        replies_checked++;
        if (exp.popped_valid) pops_with_data++;
        if (exp.status == ST_FULL) full_replies++;
        if (status_o !== exp.status || popped_value_o !== exp.popped_value ||
            popped_valid_o !== exp.popped_valid)
          note_mismatch($sformatf({"exp status=%0d value=%0d valid=%0b, ",
                                   "got status=%0d value=%0d valid=%0b"},
                                  exp.status, exp.popped_value, exp.popped_valid,
                                  status_o, popped_value_o, popped_valid_o));
      end
    end
  end

  task automatic test_missing_lists();
    send_cmd(KIND_POP, 4'd3, 1'b0, 32'd0);
    send_cmd(KIND_PUSH, 4'd3, 1'b1, 32'h1234_5678);
    send_cmd(KIND_UNUSED, 4'd5, 1'b1, 32'hFFFF_FFFF);
    send_cmd(KIND_PUSH, 4'd15, 1'b0, 32'h8000_0000);
    drain();
  endtask

  task automatic test_create_rules();
    send_cmd(KIND_CREATE, 4'd0, 1'b0, 32'hDEAD_BEEF);
    send_cmd(KIND_CREATE, 4'd0, 1'b1, 32'd0);
    send_cmd(KIND_CREATE, 4'd1, 1'b1, 32'd0);
    send_cmd(KIND_CREATE, 4'd1, 1'b0, 32'd0);
    send_cmd(KIND_CREATE, 4'd15, 1'b1, 32'd0);
    drain();
  endtask

  task automatic test_stack_order();
    send_cmd(KIND_PUSH, 4'd0, 1'b1, 32'h7FFF_FFFF);
    send_cmd(KIND_PUSH, 4'd0, 1'b0, 32'h8000_0000);
    send_cmd(KIND_PUSH, 4'd0, 1'b0, 32'hFFFF_FFFF);
    send_cmd(KIND_PUSH, 4'd0, 1'b0, 32'h0000_0000);
    repeat (5) send_cmd(KIND_POP, 4'd0, 1'b1, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_queue_order();
    send_cmd(KIND_PUSH, 4'd1, 1'b0, 32'h8000_0000);
    send_cmd(KIND_PUSH, 4'd1, 1'b0, 32'h7FFF_FFFF);
    send_cmd(KIND_PUSH, 4'd15, 1'b0, 32'h5555_5555);
    send_cmd(KIND_PUSH, 4'd1, 1'b0, 32'hAAAA_AAAA);
    repeat (3) send_cmd(KIND_POP, 4'd1, 1'b0, 32'd0);
    send_cmd(KIND_POP, 4'd15, 1'b0, 32'd0);
    drain();
  endtask

  // Exhausts the free list and bump pointer, hits store full, then returns every node.
  task automatic test_store_full();
    int id;
    for (id = 0; id < NumLists; id++)
      send_cmd(KIND_CREATE, id[3:0], 1'($urandom_range(1)), 32'd0);
    while (free_valid || fresh_ptr < NumNodes)
      send_cmd(KIND_PUSH, 4'($urandom_range(NumLists - 1)), 1'($urandom_range(1)),
               pick_value());
    send_cmd(KIND_PUSH, 4'd2, 1'b0, 32'h0F0F_0F0F);
    send_cmd(KIND_PUSH, 4'd9, 1'b1, 32'hF0F0_F0F0);
    for (id = 0; id < NumLists; id++)
      while (lst_nonempty[id]) send_cmd(KIND_POP, id[3:0], 1'($urandom_range(1)), $urandom);
    send_cmd(KIND_POP, 4'd7, 1'b0, 32'd0);
    drain();
  endtask

  // Mostly push/pop on live lists with a little create and unused-kind noise;
  // nodes now come from the recycled free list.
  task automatic test_random_mix(input int count, input int push_pct);
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 4)
        send_cmd(KIND_CREATE, 4'($urandom_range(NumLists - 1)), 1'($urandom_range(1)),
                 $urandom);
      else if (r < 7)
        send_cmd(KIND_UNUSED, 4'($urandom_range(NumLists - 1)), 1'($urandom_range(1)),
                 $urandom);
      else if (r < 7 + push_pct)
        send_cmd(KIND_PUSH, 4'($urandom_range(NumLists - 1)), 1'($urandom_range(1)),
                 pick_value());
      else
        send_cmd(KIND_POP, 4'($urandom_range(NumLists - 1)), 1'($urandom_range(1)),
                 $urandom);
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < NumLists; i++) begin
      lst_exists[i]   = 1'b0;
      lst_queue[i]    = 1'b0;
      lst_nonempty[i] = 1'b0;
      lst_head[i]     = '0;
      lst_tail[i]     = '0;
    end
    free_top        = '0;
    free_valid      = 1'b0;
    fresh_ptr       = '0;
    idle_pct        = 0;
    cmds_sent       = 0;
    replies_checked = 0;
    pops_with_data  = 0;
    full_replies    = 0;
    mismatches      = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_missing_lists();
    test_create_rules();
    idle_pct = 74;
    test_stack_order();
    idle_pct = 6;
    test_queue_order();
    test_store_full();
    idle_pct = 0;
    test_random_mix(110, 50);
    idle_pct = 74;
    test_random_mix(100, 60);
    idle_pct = 6;
    test_random_mix(100, 40);

    $display("covered %0d commands, %0d results checked: %0d pops with data, %0d store-full",
             cmds_sent, replies_checked, pops_with_data, full_replies);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("multi_list_stack_queue_engine_tb: PASS");
    end else begin
      $display("multi_list_stack_queue_engine_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout waiting on the engine");
    $display("multi_list_stack_queue_engine_tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/mlsq_pkg.sv
src/mlsq_ram.sv
src/mlsq_alloc.sv
src/multi_list_stack_queue_engine.sv
bench/multi_list_stack_queue_engine_tb.sv
